### hw/rtl/pthc_pkg.sv
// ----------------------------------------------------------------------------
// pthc_pkg
// Shared constants and helpers for the pressure, temperature and humidity
// compensation pipeline.
// ----------------------------------------------------------------------------
package pthc_pkg;

  localparam int RegIdxW   = 3;
  localparam int CfgDataW  = 48;
  localparam int RawTempW  = 20;
  localparam int RawPresW  = 20;
  localparam int RawHumW   = 16;
  localparam int TempW     = 24;
  localparam int PresW     = 32;
  localparam int HumW      = 17;
  localparam int WordW     = 32;

  // Front stages before the divider, divider steps, and back stages.
  localparam int FrontStages = 14;
  localparam int DivSteps    = 32;
  localparam int BackStages  = 3;

  // Side payload carried through the divider: temperature, humidity,
  // invalid flag and the post-doubling flag.
  localparam int SideW = TempW + HumW + 2;

  localparam logic [RegIdxW-1:0] RegCalTemp  = 3'd0;
  localparam logic [RegIdxW-1:0] RegCalPresA = 3'd1;
  localparam logic [RegIdxW-1:0] RegCalPresB = 3'd2;
  localparam logic [RegIdxW-1:0] RegCalPresC = 3'd3;
  localparam logic [RegIdxW-1:0] RegCalHumA  = 3'd4;
  localparam logic [RegIdxW-1:0] RegCalHumB  = 3'd5;

  localparam logic [WordW-1:0] KTempOffs  = 32'd64000;
  localparam logic [WordW-1:0] KPresBase  = 32'd1048576;
  localparam logic [WordW-1:0] KPresScale = 32'd3125;
  localparam logic [WordW-1:0] KHumOffs   = 32'd76800;
  localparam logic [WordW-1:0] KHumMax    = 32'd419430400;
  localparam logic [WordW-1:0] KHumBias   = 32'd2097152;
  localparam logic [WordW-1:0] KRound14   = 32'd16384;
  localparam logic [WordW-1:0] KOne15     = 32'd32768;
  localparam logic [WordW-1:0] KRound13   = 32'd8192;
  localparam logic [WordW-1:0] KRound7    = 32'd128;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x,
                                           input logic [4:0] n);
    return WordW'($signed(x) >>> n);
  endfunction

  function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [WordW-1:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

### hw/rtl/pthc_divider.sv
// ----------------------------------------------------------------------------
// pthc_divider
// Pipelined restoring unsigned 32-bit divider, one quotient bit per stage,
// with a side payload that travels alongside each beat.
// ----------------------------------------------------------------------------
module pthc_divider
  import pthc_pkg::*;
#(
  parameter int SideW_P = SideW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [WordW-1:0]   dividend_i,
  input  logic [WordW-1:0]   divisor_i,
  input  logic [SideW_P-1:0] side_i,
  output logic               valid_o,
  output logic [WordW-1:0]   quotient_o,
  output logic [SideW_P-1:0] side_o
);

  logic [WordW-1:0]   rem_c  [DivSteps+1];
  logic [WordW-1:0]   num_c  [DivSteps+1];
  logic [WordW-1:0]   dvs_c  [DivSteps+1];
  logic [SideW_P-1:0] side_c [DivSteps+1];
  logic               vld_c  [DivSteps+1];

  assign rem_c[0]  = '0;
  assign num_c[0]  = dividend_i;
  assign dvs_c[0]  = divisor_i;
  assign side_c[0] = side_i;
  assign vld_c[0]  = valid_i;

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [WordW:0]     trial;
    logic [WordW:0]     diff;
    logic               ge;
    logic [WordW-1:0]   rem_q, rem_d, num_q, num_d, dvs_q;
    logic [SideW_P-1:0] side_q;
    logic               vld_q;

    // The quotient bits fill the dividend register from the bottom.
    assign trial = {rem_c[k], num_c[k][WordW-1]};
    assign diff  = trial - {1'b0, dvs_c[k]};
    assign ge    = ~diff[WordW];
    assign rem_d = ge ? diff[WordW-1:0] : trial[WordW-1:0];
    assign num_d = {num_c[k][WordW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_c[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        num_q  <= num_d;
        dvs_q  <= dvs_c[k];
        side_q <= side_c[k];
      end
    end

    assign rem_c[k+1]  = rem_q;
    assign num_c[k+1]  = num_q;
    assign dvs_c[k+1]  = dvs_q;
    assign side_c[k+1] = side_q;
    assign vld_c[k+1]  = vld_q;
  end

  assign valid_o    = vld_c[DivSteps];
  assign quotient_o = num_c[DivSteps];
  assign side_o     = side_c[DivSteps];

endmodule

### hw/rtl/pth_sensor_compensation.sv
// ----------------------------------------------------------------------------
// pth_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples
// against calibration words held in configuration registers.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | in        | in_valid_i/in_ready_o | raw_temperature/pressure/humidity
// out     | out       | out_valid_o/out_ready_i | temperature, pressure, flag, humidity
// cfg     | in        | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One sample set is accepted per cycle while input ready is high; each result
// passes through 14 arithmetic stages, a 32-step divider and 3 correction stages.
// Reset clears the calibration registers and all valid bits.
// The whole pipeline advances together; it holds while the output register
// is full and not taken, and then input ready is low.
// ----------------------------------------------------------------------------
module pth_sensor_compensation
  import pthc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RawTempW-1:0] raw_temperature_i,
  input  logic [RawPresW-1:0] raw_pressure_i,
  input  logic [RawHumW-1:0]  raw_humidity_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TempW-1:0]    temperature_centi_o,
  output logic [PresW-1:0]    pressure_pa_o,
  output logic                pressure_invalid_o,
  output logic [HumW-1:0]     humidity_q10_o
);

  // Calibration registers.
  logic [47:0] cal_t_q, cal_pa_q, cal_pb_q, cal_pc_q;
  logic [31:0] cal_ha_q;
  logic [39:0] cal_hb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pa_q <= '0;
      cal_pb_q <= '0;
      cal_pc_q <= '0;
      cal_ha_q <= '0;
      cal_hb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCalTemp:  cal_t_q  <= cfg_wdata_i;
        RegCalPresA: cal_pa_q <= cfg_wdata_i;
        RegCalPresB: cal_pb_q <= cfg_wdata_i;
        RegCalPresC: cal_pc_q <= cfg_wdata_i;
        RegCalHumA:  cal_ha_q <= cfg_wdata_i[31:0];
        RegCalHumB:  cal_hb_q <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, cal_t_q[15:0]};
  assign t2 = sx16(cal_t_q[31:16]);
  assign t3 = sx16(cal_t_q[47:32]);
  assign p1 = {16'd0, cal_pa_q[15:0]};
  assign p2 = sx16(cal_pa_q[31:16]);
  assign p3 = sx16(cal_pa_q[47:32]);
  assign p4 = sx16(cal_pb_q[15:0]);
  assign p5 = sx16(cal_pb_q[31:16]);
  assign p6 = sx16(cal_pb_q[47:32]);
  assign p7 = sx16(cal_pc_q[15:0]);
  assign p8 = sx16(cal_pc_q[31:16]);
  assign p9 = sx16(cal_pc_q[47:32]);
  assign h1 = {24'd0, cal_ha_q[7:0]};
  assign h2 = sx16(cal_ha_q[23:8]);
  assign h3 = {24'd0, cal_ha_q[31:24]};
  assign h4 = sx16(cal_hb_q[15:0]);
  assign h5 = sx16(cal_hb_q[31:16]);
  assign h6 = sx8(cal_hb_q[39:32]);

  logic adv;
  assign adv        = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;

  // Front valid chain.
  logic [FrontStages-1:0] fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[FrontStages-2:0], in_valid_i};
    end
  end

  // Front payload registers, named by stage.
  logic [31:0] a1_q, b1_q;
  logic [19:0] rp1_q, rp2_q, rp3_q, rp4_q, rp5_q, rp6_q, rp7_q, rp8_q;
  logic [15:0] rh1_q, rh2_q, rh3_q, rh4_q, rh5_q, rh6_q;
  logic [31:0] m1_2_q, m2_2_q;
  logic [31:0] v1t_3_q, m3_3_q;
  logic [31:0] tf_4_q;
  logic [23:0] temp5_q, temp6_q, temp7_q, temp8_q, temp9_q, temp10_q;
  logic [23:0] temp11_q, temp12_q, temp13_q, temp14_q;
  logic [31:0] pv_5_q, h_5_q;
  logic [31:0] qq_6_q, mp5_6_q, mp2_6_q, mh6_6_q, mh3_6_q, mh5_6_q;
  logic [31:0] mp6_7_q, mp3_7_q, mp5_7_q, mp2_7_q, x7_q, mh_7_q;
  logic [31:0] v2_8_q, pva_8_q, yy_8_q, x8_q;
  logic [31:0] pm_9_q, num_9_q, y_9_q, x9_q;
  logic [31:0] dv_10_q, pn_10_q, hx_10_q;
  logic [31:0] dnd11_q, dnd12_q, dnd13_q, dnd14_q;
  logic [31:0] dvs11_q, dvs12_q, dvs13_q, dvs14_q;
  logic        post11_q, post12_q, post13_q, post14_q;
  logic        inv11_q, inv12_q, inv13_q, inv14_q;
  logic [31:0] hx11_q, hs11_q, hx12_q, hsq12_q, hx13_q, hm13_q;
  logic [16:0] hum14_q;

  logic [31:0] tf5x, q5, h13;
  logic [31:0] rt32;

  assign rt32 = {12'd0, raw_temperature_i};
  assign tf5x = {tf_4_q[29:0], 2'b00} + tf_4_q + KRound7;
  assign q5   = asr(pv_5_q, 5'd2);
  assign h13  = hx13_q - asr(hm13_q, 5'd4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: temperature differences.
      a1_q  <= (rt32 >> 3) - {t1[30:0], 1'b0};
      b1_q  <= (rt32 >> 4) - t1;
      rp1_q <= raw_pressure_i;
      rh1_q <= raw_humidity_i;
      // Stage 2.
      m1_2_q <= a1_q * t2;
      m2_2_q <= b1_q * b1_q;
      rp2_q  <= rp1_q;
      rh2_q  <= rh1_q;
      // Stage 3.
      v1t_3_q <= asr(m1_2_q, 5'd11);
      m3_3_q  <= asr(m2_2_q, 5'd12) * t3;
      rp3_q   <= rp2_q;
      rh3_q   <= rh2_q;
      // Stage 4: fine temperature.
      tf_4_q <= v1t_3_q + asr(m3_3_q, 5'd14);
      rp4_q  <= rp3_q;
      rh4_q  <= rh3_q;
      // Stage 5.
      temp5_q <= TempW'(asr(tf5x, 5'd8));
      pv_5_q  <= asr(tf_4_q, 5'd1) - KTempOffs;
      h_5_q   <= tf_4_q - KHumOffs;
      rp5_q   <= rp4_q;
      rh5_q   <= rh4_q;
      // Stage 6.
      qq_6_q  <= q5 * q5;
      mp5_6_q <= pv_5_q * p5;
      mp2_6_q <= p2 * pv_5_q;
      mh6_6_q <= h_5_q * h6;
      mh3_6_q <= h_5_q * h3;
      mh5_6_q <= h5 * h_5_q;
      temp6_q <= temp5_q;
      rp6_q   <= rp5_q;
      rh6_q   <= rh5_q;
      // Stage 7.
      mp6_7_q <= asr(qq_6_q, 5'd11) * p6;
      mp3_7_q <= p3 * asr(qq_6_q, 5'd13);
      mp5_7_q <= mp5_6_q;
      mp2_7_q <= mp2_6_q;
      x7_q    <= asr(({rh6_q, 14'd0} - {h4[11:0], 20'd0} - mh5_6_q) + KRound14,
                     5'd15);
      mh_7_q  <= asr(mh6_6_q, 5'd10) * (asr(mh3_6_q, 5'd11) + KOne15);
      temp7_q <= temp6_q;
      rp7_q   <= rp6_q;
      // Stage 8.
      v2_8_q  <= asr(mp6_7_q + {mp5_7_q[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'd0};
      pva_8_q <= asr(asr(mp3_7_q, 5'd3) + asr(mp2_7_q, 5'd1), 5'd18);
      yy_8_q  <= (asr(mh_7_q, 5'd10) + KHumBias) * h2;
      x8_q    <= x7_q;
      temp8_q <= temp7_q;
      rp8_q   <= rp7_q;
      // Stage 9.
      pm_9_q  <= (KOne15 + pva_8_q) * p1;
      num_9_q <= (KPresBase - {12'd0, rp8_q}) - asr(v2_8_q, 5'd12);
      y_9_q   <= asr(yy_8_q + KRound13, 5'd14);
      x9_q    <= x8_q;
      temp9_q <= temp8_q;
      // Stage 10.
      dv_10_q  <= asr(pm_9_q, 5'd15);
      pn_10_q  <= num_9_q * KPresScale;
      hx_10_q  <= x9_q * y_9_q;
      temp10_q <= temp9_q;
      // Stage 11: divider operands; large numerators are doubled afterwards.
      dnd11_q  <= pn_10_q[31] ? pn_10_q : {pn_10_q[30:0], 1'b0};
      post11_q <= pn_10_q[31];
      dvs11_q  <= dv_10_q;
      inv11_q  <= (dv_10_q == '0);
      hx11_q   <= hx_10_q;
      hs11_q   <= asr(hx_10_q, 5'd15);
      temp11_q <= temp10_q;
      // Stage 12.
      hsq12_q  <= hs11_q * hs11_q;
      hx12_q   <= hx11_q;
      dnd12_q  <= dnd11_q;
      post12_q <= post11_q;
      dvs12_q  <= dvs11_q;
      inv12_q  <= inv11_q;
      temp12_q <= temp11_q;
      // Stage 13.
      hm13_q   <= asr(hsq12_q, 5'd7) * h1;
      hx13_q   <= hx12_q;
      dnd13_q  <= dnd12_q;
      post13_q <= post12_q;
      dvs13_q  <= dvs12_q;
      inv13_q  <= inv12_q;
      temp13_q <= temp12_q;
      // Stage 14: humidity clamp.
      if (h13[31]) begin
        hum14_q <= '0;
      end else if (h13 > KHumMax) begin
        hum14_q <= KHumMax[28:12];
      end else begin
        hum14_q <= h13[28:12];
      end
      dnd14_q  <= dnd13_q;
      post14_q <= post13_q;
      dvs14_q  <= dvs13_q;
      inv14_q  <= inv13_q;
      temp14_q <= temp13_q;
    end
  end

  logic             dv_valid;
  logic [31:0]      quot;
  logic [SideW-1:0] dv_side;

  pthc_divider #(
    .SideW_P(SideW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (fv_q[FrontStages-1]),
    .dividend_i (dnd14_q),
    .divisor_i  (dvs14_q),
    .side_i     ({temp14_q, hum14_q, inv14_q, post14_q}),
    .valid_o    (dv_valid),
    .quotient_o (quot),
    .side_o     (dv_side)
  );

  // Back stages: pressure correction terms.
  logic [BackStages-1:0] bv_q;
  logic [31:0]           pq, pq3;
  logic [31:0]           p_b1_q, w2m_b1_q, pp3_b1_q, p_b2_q, w1m_b2_q, w2_b2_q;
  logic [SideW-1:0]      side_b1_q, side_b2_q;
  logic [TempW-1:0]      temp_o_q;
  logic [PresW-1:0]      pres_o_q;
  logic                  inv_o_q;
  logic [HumW-1:0]       hum_o_q;

  assign pq  = dv_side[0] ? {quot[30:0], 1'b0} : quot;
  assign pq3 = pq >> 3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (adv) begin
      bv_q <= {bv_q[BackStages-2:0], dv_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_b1_q    <= pq;
      w2m_b1_q  <= (pq >> 2) * p8;
      pp3_b1_q  <= pq3 * pq3;
      side_b1_q <= dv_side;
      p_b2_q    <= p_b1_q;
      w1m_b2_q  <= p9 * (pp3_b1_q >> 13);
      w2_b2_q   <= asr(w2m_b1_q, 5'd13);
      side_b2_q <= side_b1_q;
      pres_o_q  <= side_b2_q[1] ? '0 :
                   p_b2_q + asr(asr(w1m_b2_q, 5'd12) + w2_b2_q + p7, 5'd4);
      temp_o_q  <= side_b2_q[SideW-1 -: TempW];
      hum_o_q   <= side_b2_q[2 +: HumW];
      inv_o_q   <= side_b2_q[1];
    end
  end

  assign out_valid_o         = bv_q[BackStages-1];
  assign temperature_centi_o = temp_o_q;
  assign pressure_pa_o       = pres_o_q;
  assign pressure_invalid_o  = inv_o_q;
  assign humidity_q10_o      = hum_o_q;

endmodule

### hw/rtl/pthc_checker.sv
// ----------------------------------------------------------------------------
// pthc_checker
// Port-level checks for the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pthc_checker
  import pthc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [TempW-1:0] temperature_centi_o,
  input logic [PresW-1:0] pressure_pa_o,
  input logic             pressure_invalid_o,
  input logic [HumW-1:0]  humidity_q10_o
);

  // The pipeline moves only when the output beat can leave.
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output state");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressure_pa_o)
      && $stable(temperature_centi_o) && $stable(humidity_q10_o))
    else $error("stalled output beat changed");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_q10_o <= HumW'(102400))
    else $error("humidity above full scale");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_invalid_o |-> pressure_pa_o == '0)
    else $error("invalid pressure is not zero");

endmodule

bind pth_sensor_compensation pthc_checker u_pthc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .temperature_centi_o (temperature_centi_o),
  .pressure_pa_o       (pressure_pa_o),
  .pressure_invalid_o  (pressure_invalid_o),
  .humidity_q10_o      (humidity_q10_o)
);
